FILE: hw/rtl/bced_pkg.sv
// shared types and constants for the button click event detector
// no dependencies
`timescale 1ns / 1ps

package bced_pkg;

    localparam int TIME_W  = 32;
    localparam int MS_W    = 16;
    localparam int CODE_W  = 3;
    localparam int PHASE_W = 4;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT       = 2'd3;

    localparam logic [MS_W-1:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [MS_W-1:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [MS_W-1:0] DOUBLE_CLICK_RST = 16'd400;

    // event codes
    localparam logic [CODE_W-1:0] EV_PRESSED           = 3'd0;
    localparam logic [CODE_W-1:0] EV_LONG_PRESSED      = 3'd1;
    localparam logic [CODE_W-1:0] EV_RELEASED          = 3'd2;
    localparam logic [CODE_W-1:0] EV_CLICKED           = 3'd3;
    localparam logic [CODE_W-1:0] EV_DOUBLE_LONG_PRESS = 3'd4;
    localparam logic [CODE_W-1:0] EV_DOUBLE_CLICKED    = 3'd5;
    localparam logic [CODE_W-1:0] EV_DOUBLE_LONG_CLICK = 3'd6;
    localparam logic [CODE_W-1:0] EV_LONG_CLICKED      = 3'd7;

    typedef struct packed {
        logic              raw_level;
        logic [TIME_W-1:0] time_ms;
    } t_in_req;

    typedef struct packed {
        logic [CODE_W-1:0] event_code;
        logic              last_event;
    } t_out_req;

    typedef struct packed {
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] long_press_ms;
        logic [MS_W-1:0] double_click_ms;
        logic            invert_level;
    } t_cfg;

    // events produced by one sample, up to two
    typedef struct packed {
        logic [1:0] cnt;
        t_out_req   first;
        t_out_req   second;
    } t_evt;

endpackage

FILE: hw/rtl/bced_fsm.sv
// debounce and click classification state machine, one sample per cycle while i_step is high
// depends on bced_pkg
`timescale 1ns / 1ps

module bced_fsm import bced_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_in_req i_req,
    input  t_cfg    i_cfg,
    output t_evt    o_evt
);

    localparam logic [PHASE_W-1:0] PH_IDLE        = 4'd0;
    localparam logic [PHASE_W-1:0] PH_PRESS_DB    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_DOWN        = 4'd2;
    localparam logic [PHASE_W-1:0] PH_RELEASE_DB  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT_SECOND = 4'd4;
    localparam logic [PHASE_W-1:0] PH_PRESS2_DB   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_DOWN2       = 4'd6;
    localparam logic [PHASE_W-1:0] PH_RELEASE2_DB = 4'd7;
    localparam logic [PHASE_W-1:0] PH_DLONG       = 4'd8;
    localparam logic [PHASE_W-1:0] PH_DLONG_REL   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_LONG        = 4'd10;
    localparam logic [PHASE_W-1:0] PH_LONG_REL    = 4'd11;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [TIME_W-1:0]  r_press_time, n_press_time;
    logic [TIME_W-1:0]  r_release_time, n_release_time;

    logic              down;
    logic [TIME_W-1:0] now, since_press, since_release;
    logic              press_db_over, press_long_over, rel_db_over, rel_dc_over;
    logic [1:0]        cnt;
    logic [CODE_W-1:0] ev0, ev1;

    assign down          = i_req.raw_level ^ i_cfg.invert_level;
    assign now           = i_req.time_ms;
    assign since_press   = now - r_press_time;
    assign since_release = now - r_release_time;

    assign press_db_over   = since_press   > {{(TIME_W-MS_W){1'b0}}, i_cfg.debounce_ms};
    assign press_long_over = since_press   > {{(TIME_W-MS_W){1'b0}}, i_cfg.long_press_ms};
    assign rel_db_over     = since_release > {{(TIME_W-MS_W){1'b0}}, i_cfg.debounce_ms};
    assign rel_dc_over     = since_release > {{(TIME_W-MS_W){1'b0}}, i_cfg.double_click_ms};

    always_comb begin
        n_phase        = r_phase;
        n_press_time   = r_press_time;
        n_release_time = r_release_time;
        cnt            = 2'd0;
        ev0            = EV_PRESSED;
        ev1            = EV_PRESSED;
        unique case (r_phase)
            PH_IDLE: begin
                if (down) begin
                    n_phase      = PH_PRESS_DB;
                    n_press_time = now;
                end
            end
            PH_PRESS_DB: begin
                if (!down) begin
                    n_phase = PH_IDLE;
                end else if (press_db_over) begin
                    n_phase = PH_DOWN;
                    cnt     = 2'd1;
                    ev0     = EV_PRESSED;
                end
            end
            PH_DOWN: begin
                if (!down) begin
                    n_phase        = PH_RELEASE_DB;
                    n_release_time = now;
                end else if (press_long_over) begin
                    n_phase = PH_LONG;
                    cnt     = 2'd1;
                    ev0     = EV_LONG_PRESSED;
                end
            end
            PH_RELEASE_DB: begin
                if (down) begin
                    n_phase = PH_DOWN;
                end else if (rel_db_over) begin
                    n_phase        = PH_WAIT_SECOND;
                    n_release_time = now;
                    cnt            = 2'd1;
                    ev0            = EV_RELEASED;
                end
            end
            PH_WAIT_SECOND: begin
                if (down) begin
                    n_phase        = PH_PRESS2_DB;
                    n_release_time = now;
                end else if (rel_dc_over) begin
                    n_phase = PH_IDLE;
                    cnt     = 2'd1;
                    ev0     = EV_CLICKED;
                end
            end
            PH_PRESS2_DB: begin
                if (!down) begin
                    n_phase = PH_WAIT_SECOND;
                end else if (press_db_over) begin
                    n_phase = PH_DOWN2;
                    cnt     = 2'd1;
                    ev0     = EV_PRESSED;
                end
            end
            PH_DOWN2: begin
                if (!down) begin
                    n_phase        = PH_RELEASE2_DB;
                    n_release_time = now;
                end else if (press_long_over) begin
                    n_phase = PH_DLONG;
                    cnt     = 2'd1;
                    ev0     = EV_DOUBLE_LONG_PRESS;
                end
            end
            PH_RELEASE2_DB: begin
                if (down) begin
                    n_phase = PH_DOWN2;
                end else if (rel_db_over) begin
                    n_phase = PH_IDLE;
                    cnt     = 2'd2;
                    ev0     = EV_DOUBLE_CLICKED;
                    ev1     = EV_RELEASED;
                end
            end
            PH_DLONG: begin
                if (!down) begin
                    n_phase        = PH_DLONG_REL;
                    n_release_time = now;
                end
            end
            PH_DLONG_REL: begin
                if (down) begin
                    n_phase = PH_DLONG;
                end else if (rel_db_over) begin
                    n_phase = PH_IDLE;
                    cnt     = 2'd2;
                    ev0     = EV_DOUBLE_LONG_CLICK;
                    ev1     = EV_RELEASED;
                end
            end
            PH_LONG: begin
                if (!down) begin
                    n_phase      = PH_LONG_REL;
                    n_press_time = now;
                end
            end
            PH_LONG_REL: begin
                if (down) begin
                    n_phase = PH_LONG;
                end else if (press_db_over) begin
                    n_phase = PH_IDLE;
                    cnt     = 2'd2;
                    ev0     = EV_RELEASED;
                    ev1     = EV_LONG_CLICKED;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_evt.cnt               = i_step ? cnt : 2'd0;
        o_evt.first.event_code  = ev0;
        o_evt.first.last_event  = (cnt == 2'd1);
        o_evt.second.event_code = ev1;
        o_evt.second.last_event = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_press_time   <= '0;
            r_release_time <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_press_time   <= n_press_time;
            r_release_time <= n_release_time;
        end
    end

endmodule

FILE: hw/rtl/bced_fifo.sv
// four-entry result queue, takes up to two results per cycle, gives one unless stalled
// depends on bced_pkg
`timescale 1ns / 1ps

module bced_fifo import bced_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_evt     i_evt,
    output logic     o_room,
    output logic     o_valid,
    input  logic     i_stall,
    output t_out_req o_req
);

    t_out_req   r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_count, n_count;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign o_room  = (r_count <= 3'd2);
    assign o_req   = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_wr    = r_wr + i_evt.cnt;
        n_rd    = r_rd + {1'b0, pop};
        n_count = r_count + {1'b0, i_evt.cnt} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.cnt != 2'd0) begin
            r_mem[r_wr] <= i_evt.first;
        end
        if (i_evt.cnt == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_evt.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

FILE: hw/rtl/button_click_event_detector.sv
// top level of the button click event detector: input register, config registers
// depends on bced_pkg, bced_fsm, bced_fifo
`timescale 1ns / 1ps

// Takes one button sample (level and millisecond stamp) per cycle and emits
// zero, one or two event codes per sample on the result channel, the last one
// flagged. A sample waits in the input register, where the state machine
// evaluates it, until the queue has room; its results then go into a four-entry
// queue and are given out in order. Samples are taken back to back while the queue holds two or
// fewer results, so a steady rate of one sample per cycle is kept unless the
// result side stalls or samples yield two events in a row, in which case the
// single-result output port sets the pace. Configuration writes are applied
// immediately and belong to quiet periods.
module button_click_event_detector import bced_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_req              i_req,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_req             o_req,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MS_W-1:0]      i_cfg_data
);

    logic    r_in_valid, n_in_valid;
    t_in_req r_in;
    t_cfg    r_cfg, n_cfg;
    t_evt    evt;
    logic    room, step, accept;

    assign step    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = accept ? 1'b1 : (step ? 1'b0 : r_in_valid);
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE:     n_cfg.debounce_ms     = i_cfg_data;
                CFG_LONG_PRESS:   n_cfg.long_press_ms   = i_cfg_data;
                CFG_DOUBLE_CLICK: n_cfg.double_click_ms = i_cfg_data;
                CFG_INVERT:       n_cfg.invert_level    = i_cfg_data[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_cfg.debounce_ms     <= DEBOUNCE_RST;
            r_cfg.long_press_ms   <= LONG_PRESS_RST;
            r_cfg.double_click_ms <= DOUBLE_CLICK_RST;
            r_cfg.invert_level    <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_cfg      <= n_cfg;
        end
    end

    bced_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_in),
        .i_cfg   (r_cfg),
        .o_evt   (evt)
    );

    bced_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_req   (o_req)
    );

endmodule

FILE: tb/sv/button_click_event_detector_tb.sv
// self-checking testbench for the button click event detector: directed gestures, then
// random press sequences under several register settings, checked against a local model
// depends on bced_pkg and button_click_event_detector
`timescale 1ns / 1ps

module button_click_event_detector_tb;
    import bced_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int PHASE_SAMPLES = 70;
    localparam int SETTLE_CYCLES = 6;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE, PH_PRESS_DEB, PH_HELD, PH_RELEASE_DEB, PH_WAIT_SECOND, PH_PRESS2_DEB,
        PH_HELD2, PH_RELEASE2_DEB, PH_DLONG_HELD, PH_DLONG_RELEASE_DEB, PH_LONG_HELD,
        PH_LONG_RELEASE_DEB
    } t_det_phase;

    typedef struct packed {
        logic              lvl;
        logic [TIME_W-1:0] stamp;
        logic              typed;
        logic [1:0]        n;
        logic [CODE_W-1:0] c0;
        logic [CODE_W-1:0] c1;
    } t_sample_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_in_req              i_req;
    logic                 o_valid;
    logic                 i_stall;
    t_out_req             o_req;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [MS_W-1:0]      i_cfg_data;

    // local copy of the detector
    t_cfg              cfg;
    t_det_phase        det_phase;
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] release_time;

    t_out_req          sample_events[$];
    t_out_req          pending_events[$];
    logic [TIME_W-1:0] clock_ms;
    bit                gaps_on;
    int                mismatches;
    int                samples_sent;
    int                events_checked;
    int                quiet_cycles;

    // reset settings unless noted: click, double click, long click across the time wrap,
    // double long click starting at the top time stamp
    t_sample_row directed_rows[28] = '{
        '{1'b1, 32'd0,          1'b1, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b1, 32'd50,         1'b1, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b1, 32'd51,         1'b1, 2'd1, EV_PRESSED, EV_PRESSED},
        '{1'b0, 32'd200,        1'b1, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b0, 32'd251,        1'b1, 2'd1, EV_RELEASED, EV_RELEASED},
        '{1'b0, 32'd652,        1'b1, 2'd1, EV_CLICKED, EV_CLICKED},
        '{1'b1, 32'd1000,       1'b0, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b1, 32'd1051,       1'b0, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b0, 32'd1100,       1'b0, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b0, 32'd1151,       1'b0, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b1, 32'd1200,       1'b0, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b1, 32'd1300,       1'b0, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b0, 32'd1400,       1'b0, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b0, 32'd1451,       1'b0, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b1, 32'hFFFF_FF00,  1'b1, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b1, 32'h0000_0000,  1'b1, 2'd1, EV_PRESSED, EV_PRESSED},
        '{1'b1, 32'h0000_0400,  1'b1, 2'd1, EV_LONG_PRESSED, EV_LONG_PRESSED},
        '{1'b0, 32'h0000_0500,  1'b1, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b0, 32'h0000_0533,  1'b1, 2'd2, EV_RELEASED, EV_LONG_CLICKED},
        '{1'b1, 32'hFFFF_FFFF,  1'b1, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b1, 32'h0000_0032,  1'b1, 2'd1, EV_PRESSED, EV_PRESSED},
        '{1'b0, 32'h0000_0100,  1'b1, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b0, 32'h0000_0133,  1'b1, 2'd1, EV_RELEASED, EV_RELEASED},
        '{1'b1, 32'h0000_0200,  1'b1, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b1, 32'h0000_0201,  1'b1, 2'd1, EV_PRESSED, EV_PRESSED},
        '{1'b1, 32'h0000_03E8,  1'b1, 2'd1, EV_DOUBLE_LONG_PRESS, EV_DOUBLE_LONG_PRESS},
        '{1'b0, 32'h0000_0400,  1'b1, 2'd0, EV_PRESSED, EV_PRESSED},
        '{1'b0, 32'h0000_0433,  1'b1, 2'd2, EV_DOUBLE_LONG_CLICK, EV_RELEASED}
    };

    button_click_event_detector i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_req      (o_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic over_limit(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] since,
                                        input logic [MS_W-1:0] limit);
        logic [TIME_W-1:0] gap;
        gap = now - since;
        return gap > {{(TIME_W-MS_W){1'b0}}, limit};
    endfunction

    function automatic void note_event(input logic [CODE_W-1:0] code);
        sample_events.push_back(t_out_req'{code, 1'b0});
    endfunction

    // one sample through the detector, events left in sample_events
    function automatic void advance_detector(input t_in_req s);
        logic              down;
        logic [TIME_W-1:0] now;
        down = s.raw_level ^ cfg.invert_level;
        now  = s.time_ms;
        sample_events.delete();
        case (det_phase)
            PH_IDLE: begin
                if (down) begin
                    det_phase = PH_PRESS_DEB;
                    press_time = now;
                end
            end
            PH_PRESS_DEB: begin
                if (!down) begin
                    det_phase = PH_IDLE;
                end else if (over_limit(now, press_time, cfg.debounce_ms)) begin
                    det_phase = PH_HELD;
                    note_event(EV_PRESSED);
                end
            end
            PH_HELD: begin
                if (!down) begin
                    det_phase = PH_RELEASE_DEB;
                    release_time = now;
                end else if (over_limit(now, press_time, cfg.long_press_ms)) begin
                    det_phase = PH_LONG_HELD;
                    note_event(EV_LONG_PRESSED);
                end
            end
            PH_RELEASE_DEB: begin
                if (down) begin
                    det_phase = PH_HELD;
                end else if (over_limit(now, release_time, cfg.debounce_ms)) begin
                    det_phase = PH_WAIT_SECOND;
                    release_time = now;
                    note_event(EV_RELEASED);
                end
            end
            PH_WAIT_SECOND: begin
                if (down) begin
                    det_phase = PH_PRESS2_DEB;
                    release_time = now;
                end else if (over_limit(now, release_time, cfg.double_click_ms)) begin
                    det_phase = PH_IDLE;
                    note_event(EV_CLICKED);
                end
            end
            PH_PRESS2_DEB: begin
                if (!down) begin
                    det_phase = PH_WAIT_SECOND;
                end else if (over_limit(now, press_time, cfg.debounce_ms)) begin
                    det_phase = PH_HELD2;
                    note_event(EV_PRESSED);
                end
            end
            PH_HELD2: begin
                if (!down) begin
                    det_phase = PH_RELEASE2_DEB;
                    release_time = now;
                end else if (over_limit(now, press_time, cfg.long_press_ms)) begin
                    det_phase = PH_DLONG_HELD;
                    note_event(EV_DOUBLE_LONG_PRESS);
                end
            end
            PH_RELEASE2_DEB: begin
                if (down) begin
                    det_phase = PH_HELD2;
                end else if (over_limit(now, release_time, cfg.debounce_ms)) begin
                    det_phase = PH_IDLE;
                    note_event(EV_DOUBLE_CLICKED);
                    note_event(EV_RELEASED);
                end
            end
            PH_DLONG_HELD: begin
                if (!down) begin
                    det_phase = PH_DLONG_RELEASE_DEB;
                    release_time = now;
                end
            end
            PH_DLONG_RELEASE_DEB: begin
                if (down) begin
                    det_phase = PH_DLONG_HELD;
                end else if (over_limit(now, release_time, cfg.debounce_ms)) begin
                    det_phase = PH_IDLE;
                    note_event(EV_DOUBLE_LONG_CLICK);
                    note_event(EV_RELEASED);
                end
            end
            PH_LONG_HELD: begin
                if (!down) begin
                    det_phase = PH_LONG_RELEASE_DEB;
                    press_time = now;
                end
            end
            PH_LONG_RELEASE_DEB: begin
                if (down) begin
                    det_phase = PH_LONG_HELD;
                end else if (over_limit(now, press_time, cfg.debounce_ms)) begin
                    det_phase = PH_IDLE;
                    note_event(EV_RELEASED);
                    note_event(EV_LONG_CLICKED);
                end
            end
            default: det_phase = PH_IDLE;
        endcase
        if (sample_events.size() != 0)
            sample_events[sample_events.size()-1].last_event = 1'b1;
    endfunction

    task automatic send_sample(input t_in_req s);
        while (gaps_on && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        advance_detector(s);
        samples_sent++;
    endtask

    task automatic press_sample(input logic down, input logic [TIME_W-1:0] stamp);
        t_in_req s;
        s.raw_level = down ^ cfg.invert_level;
        s.time_ms   = stamp;
        send_sample(s);
        foreach (sample_events[e]) pending_events.push_back(sample_events[e]);
    endtask

    task automatic hold_level(input logic down, input int unsigned span);
        int unsigned elapsed;
        int unsigned step;
        elapsed = 0;
        press_sample(down, clock_ms);
        while (elapsed < span) begin
            step = $urandom_range(span / 3 + 1, 1);
            if (elapsed + step > span) step = span - elapsed;
            elapsed  += step;
            clock_ms += step;
            press_sample(down, clock_ms);
        end
        if ($urandom_range(1) == 1) begin
            clock_ms += 1;
            press_sample(down, clock_ms);
        end
    endtask

    // contact bounce ahead of a settled level
    task automatic chatter(input logic settle);
        repeat ($urandom_range(2)) begin
            clock_ms += $urandom_range(3);
            press_sample(settle, clock_ms);
            clock_ms += $urandom_range(3);
            press_sample(!settle, clock_ms);
        end
    endtask

    task automatic gesture();
        int          presses;
        int unsigned span;
        presses = $urandom_range(2, 1);
        if ($urandom_range(3) == 0) clock_ms = $urandom();
        for (int p = 0; p < presses; p++) begin
            chatter(1'b1);
            if ($urandom_range(1) == 1) span = cfg.long_press_ms + $urandom_range(2);
            else span = $urandom_range(cfg.long_press_ms);
            hold_level(1'b1, span);
            chatter(1'b0);
            if (p + 1 < presses) span = $urandom_range(cfg.double_click_ms);
            else span = $urandom_range(cfg.double_click_ms + cfg.debounce_ms + 2);
            hold_level(1'b0, span);
        end
        while (det_phase != PH_IDLE) begin
            clock_ms += ((cfg.debounce_ms > cfg.double_click_ms) ? cfg.debounce_ms
                                                                 : cfg.double_click_ms) + 1;
            press_sample(1'b0, clock_ms);
        end
    endtask

    task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic write_config(input t_cfg c);
        put_register(CFG_DEBOUNCE, c.debounce_ms);
        put_register(CFG_LONG_PRESS, c.long_press_ms);
        put_register(CFG_DOUBLE_CLICK, c.double_click_ms);
        put_register(CFG_INVERT, {{(MS_W-1){1'b0}}, c.invert_level});
        i_cfg_we <= 1'b0;
        cfg = c;
    endtask

    task automatic quiesce();
        i_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stall, in-order compare
    initial begin
        t_out_req want;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_events.size() == 0) begin
                    $error("event_code %0d arrived with no event pending", o_req.event_code);
                    mismatches++;
                end else begin
                    want = pending_events.pop_front();
                    if (o_req.event_code !== want.event_code) begin
                        $error("event_code: expected %0d, got %0d", want.event_code,
                               o_req.event_code);
                        mismatches++;
                    end
                    if (o_req.last_event !== want.last_event) begin
                        $error("last_event: expected %0d, got %0d", want.last_event,
                               o_req.last_event);
                        mismatches++;
                    end
                end
                events_checked++;
            end
            i_stall <= gaps_on && ($urandom_range(99) < 31);
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_sample_row row;
        t_in_req     s;
        t_cfg        setting;
        int          phase_start;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_DEBOUNCE;
        i_cfg_data = '0;
        gaps_on    = 1'b1;
        mismatches = 0;
        samples_sent   = 0;
        events_checked = 0;
        clock_ms   = '0;
        cfg        = '{DEBOUNCE_RST, LONG_PRESS_RST, DOUBLE_CLICK_RST, 1'b0};
        det_phase  = PH_IDLE;
        press_time   = '0;
        release_time = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            s.raw_level = row.lvl;
            s.time_ms   = row.stamp;
            send_sample(s);
            if (row.typed) begin
                if (row.n != 0) pending_events.push_back(t_out_req'{row.c0, row.n == 2'd1});
                if (row.n == 2) pending_events.push_back(t_out_req'{row.c1, 1'b1});
            end else begin
                foreach (sample_events[e]) pending_events.push_back(sample_events[e]);
            end
        end
        quiesce();

        for (int k = 0; k < 5; k++) begin
            case (k)
                0: setting = '{16'd0, 16'd0, 16'd0, 1'b1};
                1: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};
                default: setting = '{MS_W'($urandom_range(80, 1)),
                                     MS_W'($urandom_range(1500)),
                                     MS_W'($urandom_range(600)),
                                     1'($urandom_range(1))};
            endcase
            // one setting runs flat out with no idling on either side
            gaps_on = (k != 2);
            write_config(setting);
            phase_start = samples_sent;
            while (samples_sent - phase_start < PHASE_SAMPLES) begin
                if ($urandom_range(7) == 0) begin
                    repeat ($urandom_range(4, 1)) press_sample(1'($urandom_range(1)), $urandom());
                end else begin
                    gesture();
                end
            end
            quiesce();
        end

        if (pending_events.size() != 0) begin
            $error("%0d events never arrived", pending_events.size());
            mismatches++;
        end
        $display("%0d button samples sent, %0d events checked over six register settings",
                 samples_sent, events_checked);
        $display("gestures with bounce, time wrap and random noise; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
